@@ design/bgm_pkg.sv @@
package bgm_pkg;

  // Line store geometry
  localparam int MAX_WIDTH    = 2048;
  localparam int HEADER_BYTES = 54;

  localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ADDR_W  = COL_W + 1;
  localparam int RAM_DEPTH = 2 ** ADDR_W;
  localparam int BYTE_W  = 8;
  localparam int IMG_W_W = 24;

  // Header counter must also reach the width byte positions
  localparam int HDR_CAP = (HEADER_BYTES + 1 > 21) ? HEADER_BYTES + 1 : 21;
  localparam int HDR_W   = $clog2(HDR_CAP);

  // Header byte positions of the little-endian image width
  localparam int WIDTH_POS_LO  = 18;
  localparam int WIDTH_POS_MID = 19;
  localparam int WIDTH_POS_HI  = 20;

  // 8.8 fixed-point gray weights for b, g, r
  localparam int GRAY_SUM_W = 16;
  localparam int WEIGHT_B   = 18;
  localparam int WEIGHT_G   = 184;
  localparam int WEIGHT_R   = 54;

  // Request queue depth; two entries keep reads ahead of bank reuse
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Input item kind on tuser
  typedef enum logic {
    OP_BYTE  = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  // Output request: either a plain byte or a line store read
  typedef struct packed {
    logic              from_ram;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              err;
  } bgm_req_t;

  // Line store write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } bgm_wr_t;

endpackage

@@ design/bgm_ram.sv @@
module bgm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/bgm_front.sv @@
module bgm_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic                       op_i,
  input  logic [bgm_pkg::BYTE_W-1:0] byte_i,
  input  logic                       eof_i,
  input  logic                       q_full_i,
  output logic                       push_o,
  output bgm_pkg::bgm_req_t          req_o,
  output bgm_pkg::bgm_wr_t           wr_o
);
  import bgm_pkg::*;

  typedef enum logic [2:0] {
    PH_BLUE  = 3'b001,
    PH_GREEN = 3'b010,
    PH_RED   = 3'b100
  } phase_e;

  localparam logic [1:0] LAST_SUB = 2'd2;

  logic [HDR_W-1:0]   hdr_q, hdr_d;
  logic [IMG_W_W-1:0] width_q, width_d;
  phase_e             phase_q, phase_d;
  logic [BYTE_W-1:0]  blue_q, blue_d, green_q, green_d;
  logic [COL_W-1:0]   wcol_q, wcol_d;
  logic               bank_q, bank_d;
  logic               pend_q, pend_d;
  logic [COL_W-1:0]   rcol_q, rcol_d;
  logic [1:0]         rsub_q, rsub_d;
  logic               fin_q, fin_d;

  logic                  accept;
  logic [GRAY_SUM_W-1:0] gray_sum;
  logic [COL_W-1:0]      last_col;
  logic                  row_done;

  function automatic logic width_ok(input logic [IMG_W_W-1:0] w);
    return (w != '0) && (w <= IMG_W_W'(MAX_WIDTH));
  endfunction

  assign ready_o  = !q_full_i;
  assign accept   = valid_i && ready_o;
  assign last_col = COL_W'(width_q - IMG_W_W'(1));

  // Weighted gray value of the held pixel
  assign gray_sum = GRAY_SUM_W'(WEIGHT_B) * GRAY_SUM_W'(blue_q)
                  + GRAY_SUM_W'(WEIGHT_G) * GRAY_SUM_W'(green_q)
                  + GRAY_SUM_W'(WEIGHT_R) * GRAY_SUM_W'(byte_i);

  // Classify the item and update the stream state
  always_comb begin
    hdr_d    = hdr_q;
    width_d  = width_q;
    phase_d  = phase_q;
    blue_d   = blue_q;
    green_d  = green_q;
    wcol_d   = wcol_q;
    bank_d   = bank_q;
    pend_d   = pend_q;
    rcol_d   = rcol_q;
    rsub_d   = rsub_q;
    fin_d    = fin_q;
    row_done = 1'b0;
    push_o   = 1'b0;
    req_o    = '0;
    wr_o     = '0;
    wr_o.addr = {bank_q, wcol_q};
    wr_o.data = gray_sum[GRAY_SUM_W-1 -: BYTE_W];
    req_o.addr = {~bank_q, rcol_q};

    // Mirrored read step of the pending row
    if (accept && pend_q && (op_i == OP_DRAIN || (!fin_q && hdr_q == HDR_W'(HEADER_BYTES)
                                                  && width_ok(width_q)))) begin
      req_o.from_ram = 1'b1;
      push_o         = 1'b1;
      if (rsub_q == LAST_SUB) begin
        rsub_d = '0;
        if (rcol_q == '0) begin
          pend_d = 1'b0;
        end else begin
          rcol_d = rcol_q - COL_W'(1);
        end
      end else begin
        rsub_d = rsub_q + 2'd1;
      end
    end

    if (accept && op_i == OP_DRAIN) begin
      req_o.last = fin_q && !pend_d;
    end else if (accept && !fin_q) begin
      fin_d = eof_i;
      if (hdr_q != HDR_W'(HEADER_BYTES)) begin
        // Header byte: echo and pick up the width
        case (hdr_q)
          HDR_W'(WIDTH_POS_LO):  width_d = {width_q[23:8], byte_i};
          HDR_W'(WIDTH_POS_MID): width_d = {width_q[23:16], byte_i, width_q[7:0]};
          HDR_W'(WIDTH_POS_HI):  width_d = {byte_i, width_q[15:0]};
          default:               width_d = width_q;
        endcase
        hdr_d      = hdr_q + HDR_W'(1);
        push_o     = 1'b1;
        req_o.data = byte_i;
        req_o.last = eof_i;
        req_o.err  = (hdr_q == HDR_W'(HEADER_BYTES - 1)) && !width_ok(width_d);
      end else if (!width_ok(width_q)) begin
        // Bad width: discard pixel byte
        push_o     = 1'b1;
        req_o.last = eof_i;
        req_o.err  = 1'b1;
      end else begin
        // Pixel byte
        case (phase_q)
          PH_BLUE: begin
            blue_d  = byte_i;
            phase_d = PH_GREEN;
          end
          PH_GREEN: begin
            green_d = byte_i;
            phase_d = PH_RED;
          end
          PH_RED: begin
            wr_o.en = 1'b1;
            phase_d = PH_BLUE;
            if (wcol_q == last_col) begin
              wcol_d   = '0;
              bank_d   = ~bank_q;
              pend_d   = 1'b1;
              rcol_d   = last_col;
              rsub_d   = '0;
              row_done = 1'b1;
            end else begin
              wcol_d = wcol_q + COL_W'(1);
            end
          end
          default: phase_d = PH_BLUE;
        endcase
        req_o.last = eof_i && !row_done && !pend_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q   <= '0;
      width_q <= '0;
      phase_q <= PH_BLUE;
      blue_q  <= '0;
      green_q <= '0;
      wcol_q  <= '0;
      bank_q  <= 1'b0;
      pend_q  <= 1'b0;
      rcol_q  <= '0;
      rsub_q  <= '0;
      fin_q   <= 1'b0;
    end else begin
      hdr_q   <= hdr_d;
      width_q <= width_d;
      phase_q <= phase_d;
      blue_q  <= blue_d;
      green_q <= green_d;
      wcol_q  <= wcol_d;
      bank_q  <= bank_d;
      pend_q  <= pend_d;
      rcol_q  <= rcol_d;
      rsub_q  <= rsub_d;
      fin_q   <= fin_d;
    end
  end

endmodule

@@ design/bgm_queue.sv @@
module bgm_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bgm_pkg::bgm_req_t req_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output bgm_pkg::bgm_req_t req_o
);
  import bgm_pkg::*;

  bgm_req_t          slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign req_o   = slot_q[rptr_q];
  assign do_pop  = pop_i && valid_o;

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= req_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
      end
      case ({push_i, do_pop})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ design/bgm_back.sv @@
module bgm_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  bgm_pkg::bgm_req_t           q_req_i,
  output logic                        pop_o,
  output logic                        ram_re_o,
  output logic [bgm_pkg::ADDR_W-1:0]  ram_raddr_o,
  input  logic [bgm_pkg::BYTE_W-1:0]  ram_rdata_i,
  output logic                        m_valid_o,
  input  logic                        m_ready_i,
  output logic [bgm_pkg::BYTE_W-1:0]  m_data_o,
  output logic                        m_last_o,
  output logic                        m_err_o
);
  import bgm_pkg::*;

  logic     out_vld_q;
  bgm_req_t out_req_q;

  // Advance when the output stage is empty or being taken
  assign pop_o       = q_valid_i && (!out_vld_q || m_ready_i);
  assign ram_re_o    = pop_o && q_req_i.from_ram;
  assign ram_raddr_o = q_req_i.addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || m_ready_i) begin
      out_vld_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_req_q <= q_req_i;
    end
  end

  // Read data lines up with the output stage
  assign m_valid_o = out_vld_q;
  assign m_data_o  = out_req_q.from_ram ? ram_rdata_i : out_req_q.data;
  assign m_last_o  = out_req_q.last;
  assign m_err_o   = out_req_q.err;

endmodule

@@ design/bmp_gray_mirror_rows_unit.sv @@
// Latency: an accepted input byte passes through the request queue and the output register before its output byte.
// Throughput: one input byte per cycle while the request queue is not full; the output side may stall freely.
// Per-byte timing is set by the two-entry request queue and the registered
// read port of the two-bank line store.
// Reset (rst_ni low, async): header, row and emit state clear; the line
// store is not cleared and needs no clearing pass.
module bmp_gray_mirror_rows_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [bgm_pkg::BYTE_W-1:0] s_axis_tdata,   // [7:0] data_byte
  input  logic                       s_axis_tlast,   // end_of_file
  input  logic                       s_axis_tuser,   // op
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [bgm_pkg::BYTE_W-1:0] m_axis_tdata,   // [7:0] out_byte
  output logic                       m_axis_tlast,   // final_byte
  output logic                       m_axis_tuser    // width_error
);
  import bgm_pkg::*;

  logic              q_full, q_push, q_pop, q_valid;
  bgm_req_t          push_req, q_req;
  bgm_wr_t           wr;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  bgm_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .op_i     (s_axis_tuser),
    .byte_i   (s_axis_tdata),
    .eof_i    (s_axis_tlast),
    .q_full_i (q_full),
    .push_o   (q_push),
    .req_o    (push_req),
    .wr_o     (wr)
  );

  bgm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .req_i   (push_req),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .req_o   (q_req)
  );

  // Two-bank line store, bank select in the top address bit
  bgm_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bgm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_req_i     (q_req),
    .pop_o       (q_pop),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata),
    .m_last_o    (m_axis_tlast),
    .m_err_o     (m_axis_tuser)
  );

endmodule

@@ design/bgm_checker.sv @@
module bgm_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  input  logic                       s_axis_tready,
  input  logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic [bgm_pkg::BYTE_W-1:0] m_axis_tdata,
  input  logic                       m_axis_tlast,
  input  logic                       m_axis_tuser
);
  import bgm_pkg::*;

  logic        in_acc, out_acc;
  logic [15:0] outstanding_q;
  logic        done_q;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Requests taken minus results delivered, saturating
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
      done_q        <= 1'b0;
    end else begin
      if (in_acc && !out_acc && outstanding_q != '1) begin
        outstanding_q <= outstanding_q + 16'd1;
      end else if (!in_acc && out_acc && outstanding_q != '0) begin
        outstanding_q <= outstanding_q - 16'd1;
      end
      if (out_acc && m_axis_tlast) begin
        done_q <= 1'b1;
      end
    end
  end

  // Stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("result payload changed under stall");

  // Every result follows an earlier request
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> outstanding_q != '0)
    else $error("result without a pending request");

  // Nothing follows the final byte of the image
  a_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !m_axis_tvalid)
    else $error("result after final byte");

  // No result straight out of reset
  a_reset_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind bmp_gray_mirror_rows_unit bgm_checker u_bgm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

@@ bench/bmp_gray_mirror_rows_unit_test.sv @@
`timescale 1ns / 1ps

module bmp_gray_mirror_rows_unit_test;
  import bgm_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 6;
  localparam int TAIL_CYCLES  = 10;
  localparam int RANDOM_REQS  = 330;
  localparam int RUN_LIMIT_NS = 50_000_000;

  // 8.8 fixed-point luma weights (0.07, 0.72, 0.21)
  localparam int LUMA_B = 18;
  localparam int LUMA_G = 184;
  localparam int LUMA_R = 54;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       final_byte;
    logic       width_error;
  } gray_result_t;

  logic       clk      = 1'b0;
  logic       rst_n    = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data  = 8'h00;
  logic       in_last  = 1'b0;
  op_e        in_user  = OP_BYTE;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_data;
  logic       out_last;
  logic       out_user;

  bmp_gray_mirror_rows_unit u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (in_valid),
    .s_axis_tready (in_ready),
    .s_axis_tdata  (in_data),
    .s_axis_tlast  (in_last),
    .s_axis_tuser  (in_user),
    .m_axis_tvalid (out_valid),
    .m_axis_tready (out_ready),
    .m_axis_tdata  (out_data),
    .m_axis_tlast  (out_last),
    .m_axis_tuser  (out_user)
  );

  always #HALF_PERIOD clk = ~clk;

  // Predictor state, all zero after the single reset
  logic [5:0]  hdr_cnt   = '0;
  logic [23:0] img_w     = '0;
  logic [1:0]  rgb_phase = '0;
  logic [7:0]  blue_q    = '0;
  logic [7:0]  green_q   = '0;
  logic [11:0] wr_col    = '0;
  logic        wr_bank   = 1'b0;
  logic        row_ready = 1'b0;
  logic [12:0] rd_pos    = '0;
  logic        file_done = 1'b0;
  logic [7:0]  gray_line [2*MAX_WIDTH];

  gray_result_t pending_results[$];
  int           mismatches = 0;

  // Sender bookkeeping
  int burst_left = 0;
  int line_width;

  function automatic int row_bytes();
    return 3 * int'(img_w);
  endfunction

  function automatic bit width_bad();
    return img_w == 0 || img_w > MAX_WIDTH;
  endfunction

  // Next byte of the finished row, read right to left, each gray value 3x
  function automatic logic [7:0] next_mirror_byte();
    int         col;
    logic [7:0] v;
    col = int'(rd_pos) / 3;
    v   = 8'h00;
    if (col < int'(img_w) && !width_bad())
      v = gray_line[int'(!wr_bank) * MAX_WIDTH + int'(img_w) - 1 - col];
    rd_pos = rd_pos + 13'd1;
    if (int'(rd_pos) >= row_bytes()) row_ready = 1'b0;
    return v;
  endfunction

  // Work out the result (if any) of one accepted request
  task automatic predict_request(input op_e op, input logic [7:0] din, input logic eof);
    gray_result_t r;
    logic         emitted;
    logic         row_done;
    logic [7:0]   v;
    int           gray;
    emitted  = 1'b0;
    row_done = 1'b0;
    v        = 8'h00;

    if (op == OP_DRAIN) begin
      if (row_ready && int'(rd_pos) < row_bytes()) begin
        v = next_mirror_byte();
        pending_results.push_back('{v, file_done && !row_ready, 1'b0});
      end
      return;
    end

    // bytes past end of file are dropped
    if (file_done) return;
    if (eof) file_done = 1'b1;

    // header: echo, capture little-endian width
    if (hdr_cnt < HEADER_BYTES) begin
      case (int'(hdr_cnt))
        WIDTH_POS_LO:  img_w[7:0]   = din;
        WIDTH_POS_MID: img_w[15:8]  = din;
        WIDTH_POS_HI:  img_w[23:16] = din;
        default: ;
      endcase
      hdr_cnt = hdr_cnt + 6'd1;
      r = '{din, eof, hdr_cnt == HEADER_BYTES && width_bad()};
      pending_results.push_back(r);
      return;
    end

    if (width_bad()) begin
      pending_results.push_back('{8'h00, eof, 1'b1});
      return;
    end

    // emit from the previous row before the store write
    if (row_ready && int'(rd_pos) < row_bytes()) begin
      v       = next_mirror_byte();
      emitted = 1'b1;
    end

    case (rgb_phase)
      2'd0: begin
        blue_q    = din;
        rgb_phase = 2'd1;
      end
      2'd1: begin
        green_q   = din;
        rgb_phase = 2'd2;
      end
      default: begin
        gray = (LUMA_B * blue_q + LUMA_G * green_q + LUMA_R * din) >> 8;
        gray_line[int'(wr_bank) * MAX_WIDTH + int'(wr_col)] = 8'(gray);
        rgb_phase = 2'd0;
        wr_col    = wr_col + 12'd1;
        if (wr_col >= img_w) begin
          wr_col    = '0;
          wr_bank   = ~wr_bank;
          row_ready = 1'b1;
          rd_pos    = '0;
          row_done  = 1'b1;
        end
      end
    endcase

    if (emitted) pending_results.push_back('{v, eof && !row_done && !row_ready, 1'b0});
  endtask

  // Input monitor and output checker
  always @(posedge clk) begin : scoreboard
    gray_result_t want;
    if (rst_n) begin
      if (in_valid && in_ready) predict_request(in_user, in_data, in_last);
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: out_byte %02h final %0b err %0b",
                 out_data, out_last, out_user);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (out_data !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, out_data);
            mismatches++;
          end
          if (out_last !== want.final_byte) begin
            $error("final_byte: expected %0b, got %0b", want.final_byte, out_last);
            mismatches++;
          end
          if (out_user !== want.width_error) begin
            $error("width_error: expected %0b, got %0b", want.width_error, out_user);
            mismatches++;
          end
        end
      end
    end
  end

  // Receiver stalls: a 16-bit ready mask, replaced each time the 6-bit age counter wraps
  logic [15:0] ready_mask = 16'hFFFF;
  logic [5:0]  mask_age   = '0;

  always @(posedge clk) begin
    mask_age <= mask_age + 6'd1;
    if (mask_age == 0)
      ready_mask <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom | $urandom);
    out_ready <= ready_mask[mask_age[3:0]];
  end

  // Send one request; bursts of random length with random gaps between
  task automatic send_request(input op_e op, input logic [7:0] din, input logic eof);
    int gap;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_user  <= op;
    in_data  <= din;
    in_last  <= eof;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  task automatic send_drain();
    send_request(OP_DRAIN, 8'($urandom), 1'($urandom));
  endtask

  task automatic send_pixel(input logic [7:0] din, input logic eof);
    send_request(OP_BYTE, din, eof);
  endtask

  // Hold the sender until every predicted result has come out
  task automatic hold_until_drained();
    in_valid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Header echo with the width bytes of a short row
  task automatic test_header();
    logic [7:0] b;
    line_width = $urandom_range(1, 9);
    for (int k = 0; k < HEADER_BYTES; k++) begin
      case (k)
        0:             b = 8'h42;
        1:             b = 8'h4D;
        2:             b = 8'h00;
        3:             b = 8'hFF;
        WIDTH_POS_LO:  b = line_width[7:0];
        WIDTH_POS_MID: b = line_width[15:8];
        WIDTH_POS_HI:  b = line_width[23:16];
        default:       b = 8'($urandom);
      endcase
      // drain tick while nothing is pending: no result
      if (k == 10) send_drain();
      send_pixel(b, 1'b0);
    end
  endtask

  // Black, white, primaries and a checker pattern, with drain ticks mixed in
  task automatic test_first_row_extremes();
    logic [7:0] corner_px [18] = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
                                   8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00,
                                   8'h00, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h55};
    for (int k = 0; k < 18; k++) begin
      if (k % 4 == 3) send_drain();
      send_pixel(corner_px[k], 1'b0);
    end
  endtask

  // Long stream of pixel bytes with occasional early drain ticks, held halfway until drained
  task automatic test_random_rows();
    int         n;
    logic [7:0] b;
    n = RANDOM_REQS;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) hold_until_drained();
      if ($urandom_range(0, 9) == 0) begin
        send_drain();
      end else begin
        case ($urandom_range(0, 15))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = 8'($urandom);
        endcase
        send_pixel(b, 1'b0);
      end
    end
  endtask

  // End of file at a row end, inside a row, or on the last pending byte
  task automatic test_end_of_file();
    int tail_mode;
    int to_row_end;
    hold_until_drained();
    tail_mode  = $urandom_range(0, 2);
    to_row_end = row_bytes() - (3 * int'(wr_col) + int'(rgb_phase));
    for (int k = 1; k <= to_row_end; k++)
      send_pixel(8'($urandom), tail_mode == 0 && k == to_row_end);
    // now a whole row is pending and a fresh row has started
    if (tail_mode == 1) begin
      send_pixel(8'($urandom), 1'b1);
    end else if (tail_mode == 2) begin
      send_drain();
      for (int k = 0; k < row_bytes() - 2; k++) send_pixel(8'($urandom), 1'b0);
      send_pixel(8'($urandom), 1'b1);
    end
    // flush the last row; bytes after end of file must be ignored
    for (int k = 0; k < row_bytes() + 4; k++) begin
      if (k % 5 == 2) send_request(OP_BYTE, 8'($urandom), 1'($urandom));
      send_drain();
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_header();
    test_first_row_extremes();
    test_random_rows();
    test_end_of_file();
    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

endmodule
